// ===== hw/rtl/vdib_pkg.sv =====
// Shared types and constants for the vertex dedup index builder.
`timescale 1ns / 1ps
`default_nettype none

package vdib_pkg;

  // Default storage depths.
  localparam int TABLE_DEPTH_DEFAULT = 1024;
  localparam int INDEX_DEPTH_DEFAULT = 4096;

  // Fixed field widths of the ports.
  localparam int VWORD_W = 64;
  localparam int VLAST_W = 32;
  localparam int VERTEX_W = 6 * VWORD_W + VLAST_W;
  localparam int VIDX_W = 10;
  localparam int LPOS_W = 12;
  localparam int STATUS_W = 2;
  localparam int VLIM_W = 11;
  localparam int ILIM_W = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;

  // Reset values of the limit registers.
  localparam logic [VLIM_W-1:0] VLIM_RESET = 11'd1024;
  localparam logic [ILIM_W-1:0] ILIM_RESET = 13'd4096;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIANGLE_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LIMIT = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_LIST_FULL = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SEARCH,
    S_COMMIT,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vdib_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module vdib_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vertex_dedup_index_builder_unit.sv =====
// The search reads one vertex table entry per cycle through a shared 416-bit comparator.
// A new vertex is taken only after the last one's result is handed on; in_ready is high only in idle.
// A finished result waits in the output register while the next vertex is taken.
// Reset (rst, synchronous) clears the table count, both list fills, the sequencer and the result valid flag,
// and returns the limits to their defaults; table and list contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module vertex_dedup_index_builder_unit
  import vdib_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
  parameter int INDEX_DEPTH = INDEX_DEPTH_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Configuration channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // Input channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  kind,
  input  wire logic [VWORD_W-1:0]    vertex_word_0,
  input  wire logic [VWORD_W-1:0]    vertex_word_1,
  input  wire logic [VWORD_W-1:0]    vertex_word_2,
  input  wire logic [VWORD_W-1:0]    vertex_word_3,
  input  wire logic [VWORD_W-1:0]    vertex_word_4,
  input  wire logic [VWORD_W-1:0]    vertex_word_5,
  input  wire logic [VLAST_W-1:0]    vertex_word_6,
  // Output channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [VIDX_W-1:0]          vertex_index,
  output logic                       was_new,
  output logic [LPOS_W-1:0]          list_position,
  output logic [STATUS_W-1:0]        status
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IW = $clog2(INDEX_DEPTH);
  localparam int FILL_W = $clog2(INDEX_DEPTH + 1);
  localparam int TCMP_W = (CNT_W > VLIM_W) ? CNT_W : VLIM_W;
  localparam int FCMP_W = (FILL_W > ILIM_W) ? FILL_W : ILIM_W;

  // Sequencer and bookkeeping registers.
  state_t              state, state_next;
  logic [CNT_W-1:0]    scan_idx, scan_idx_next;
  logic                cmp_valid, cmp_valid_next;
  logic [AW-1:0]       cmp_idx, cmp_idx_next;
  logic [AW-1:0]       found, found_next;
  logic                fresh, fresh_next;
  logic [LPOS_W-1:0]   slot, slot_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [CNT_W-1:0]    stored_vertices, stored_vertices_next;
  logic [FILL_W-1:0]   triangle_fill, triangle_fill_next;
  logic [FILL_W-1:0]   line_fill, line_fill_next;
  logic                out_valid_next;

  // Configuration registers.
  logic [VLIM_W-1:0]   vertex_limit;
  logic [ILIM_W-1:0]   triangle_index_limit;
  logic [ILIM_W-1:0]   line_index_limit;

  // Captured input vertex.
  logic                kind_q;
  logic [VERTEX_W-1:0] vertex_key;

  // Memory ports.
  logic                tab_we;
  logic [VERTEX_W-1:0] tab_rdata;
  logic                tri_we;
  logic                line_we;

  // Effective limits, clamped to the storage depths.
  logic [TCMP_W-1:0]   vert_cap;
  logic [FCMP_W-1:0]   list_cap;
  logic [FILL_W-1:0]   sel_fill;
  logic [ILIM_W-1:0]   sel_limit;
  logic                hit;
  logic                in_beat;

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_beat = in_valid && in_ready;

  assign vert_cap = (TCMP_W'(vertex_limit) < TCMP_W'(TABLE_DEPTH))
                  ? TCMP_W'(vertex_limit) : TCMP_W'(TABLE_DEPTH);
  assign sel_fill = kind_q ? line_fill : triangle_fill;
  assign sel_limit = kind_q ? line_index_limit : triangle_index_limit;
  assign list_cap = (FCMP_W'(sel_limit) < FCMP_W'(INDEX_DEPTH))
                  ? FCMP_W'(sel_limit) : FCMP_W'(INDEX_DEPTH);

  // Shared comparator: one stored entry against the captured vertex per cycle.
  assign hit = (tab_rdata == vertex_key);

  // Vertex table, all seven words side by side.
  vdib_ram #(
    .WIDTH (VERTEX_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tab_we),
    .waddr (stored_vertices[AW-1:0]),
    .wdata (vertex_key),
    .raddr (scan_idx[AW-1:0]),
    .rdata (tab_rdata)
  );

  // Triangle and line index lists; they are only written here.
  vdib_ram #(
    .WIDTH (VIDX_W),
    .DEPTH (INDEX_DEPTH)
  ) u_triangle_list (
    .clk   (clk),
    .we    (tri_we),
    .waddr (triangle_fill[IW-1:0]),
    .wdata (VIDX_W'(found)),
    .raddr (triangle_fill[IW-1:0]),
    .rdata ()
  );

  vdib_ram #(
    .WIDTH (VIDX_W),
    .DEPTH (INDEX_DEPTH)
  ) u_line_list (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_fill[IW-1:0]),
    .wdata (VIDX_W'(found)),
    .raddr (line_fill[IW-1:0]),
    .rdata ()
  );

  // Next state and datapath control.
  always_comb begin
    state_next = state;
    scan_idx_next = scan_idx;
    cmp_valid_next = 1'b0;
    cmp_idx_next = cmp_idx;
    found_next = found;
    fresh_next = fresh;
    slot_next = slot;
    res_status_next = res_status;
    stored_vertices_next = stored_vertices;
    triangle_fill_next = triangle_fill;
    line_fill_next = line_fill;
    out_valid_next = out_valid && !out_ready;
    tab_we = 1'b0;
    tri_we = 1'b0;
    line_we = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_beat) begin
          found_next = '0;
          fresh_next = 1'b0;
          slot_next = '0;
          res_status_next = STATUS_OK;
          state_next = S_CHECK;
        end
      end

      // The chosen list must have room before the table is touched.
      S_CHECK: begin
        if (FCMP_W'(sel_fill) >= list_cap) begin
          res_status_next = STATUS_LIST_FULL;
          state_next = S_FINISH;
        end else begin
          scan_idx_next = '0;
          state_next = S_SEARCH;
        end
      end

      // Issue one read per cycle and compare the entry read the cycle before.
      S_SEARCH: begin
        if (cmp_valid && hit) begin
          found_next = cmp_idx;
          fresh_next = 1'b0;
          state_next = S_COMMIT;
        end else if (scan_idx < stored_vertices) begin
          cmp_valid_next = 1'b1;
          cmp_idx_next = scan_idx[AW-1:0];
          scan_idx_next = scan_idx + 1'b1;
        end else if (TCMP_W'(stored_vertices) >= vert_cap) begin
          res_status_next = STATUS_TABLE_FULL;
          state_next = S_FINISH;
        end else begin
          tab_we = 1'b1;
          found_next = stored_vertices[AW-1:0];
          fresh_next = 1'b1;
          stored_vertices_next = stored_vertices + 1'b1;
          state_next = S_COMMIT;
        end
      end

      // Append the index to the chosen list.
      S_COMMIT: begin
        slot_next = LPOS_W'(sel_fill);
        if (kind_q) begin
          line_we = 1'b1;
          line_fill_next = line_fill + 1'b1;
        end else begin
          tri_we = 1'b1;
          triangle_fill_next = triangle_fill + 1'b1;
        end
        state_next = S_FINISH;
      end

      // Hand the result to the output register once it is free.
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cmp_valid <= 1'b0;
      stored_vertices <= '0;
      triangle_fill <= '0;
      line_fill <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cmp_valid <= cmp_valid_next;
      stored_vertices <= stored_vertices_next;
      triangle_fill <= triangle_fill_next;
      line_fill <= line_fill_next;
      out_valid <= out_valid_next;
    end
  end

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_limit <= VLIM_RESET;
      triangle_index_limit <= ILIM_RESET;
      line_index_limit <= ILIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_VERTEX_LIMIT:   vertex_limit <= cfg_data[VLIM_W-1:0];
        CFG_TRIANGLE_LIMIT: triangle_index_limit <= cfg_data[ILIM_W-1:0];
        CFG_LINE_LIMIT:     line_index_limit <= cfg_data[ILIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    cmp_idx <= cmp_idx_next;
    found <= found_next;
    fresh <= fresh_next;
    slot <= slot_next;
    res_status <= res_status_next;
    if (in_beat) begin
      kind_q <= kind;
      vertex_key <= {vertex_word_6, vertex_word_5, vertex_word_4, vertex_word_3,
                     vertex_word_2, vertex_word_1, vertex_word_0};
    end
    if (state == S_FINISH && (!out_valid || out_ready)) begin
      vertex_index <= VIDX_W'(found);
      was_new <= fresh;
      list_position <= slot;
      status <= res_status;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vdib_checker.sv =====
// Port-level checker for the vertex dedup index builder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module vdib_checker
  import vdib_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [VIDX_W-1:0]     vertex_index,
  input wire logic                  was_new,
  input wire logic [LPOS_W-1:0]     list_position,
  input wire logic [STATUS_W-1:0]   status
);

  // A stalled result beat holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(vertex_index) && $stable(status)
      && $stable(list_position) && $stable(was_new))
    else $error("stalled result beat changed");

  // Error results carry zero index, flag and position.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STATUS_OK) |->
      (vertex_index == '0) && !was_new && (list_position == '0))
    else $error("error result carries nonzero fields");

  // Only defined status codes appear.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == STATUS_OK) || (status == STATUS_TABLE_FULL)
      || (status == STATUS_LIST_FULL))
    else $error("undefined status code");

  // After a vertex is taken the block is not ready in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind vertex_dedup_index_builder_unit vdib_checker u_vdib_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .vertex_index  (vertex_index),
  .was_new       (was_new),
  .list_position (list_position),
  .status        (status)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for the vertex dedup index builder unit.
`timescale 1ns / 1ps

module tb_top;
  import vdib_pkg::*;

  localparam int CLK_PERIOD = 8;
  // Slowest run: about 600 vertices, each searching at most the whole table,
  // with idle gaps on both sides and one long hold-off. Several times over.
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int HOLD_CYCLES = 3000;
  localparam int TAIL_CYCLES = TABLE_DEPTH_DEFAULT + 16;
  // Index past the last register; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef logic [VERTEX_W-1:0] vertex_t;

  typedef struct packed {
    logic    kind;
    vertex_t vtx;
  } vertex_beat_t;

  typedef struct packed {
    logic [VIDX_W-1:0]   vertex_index;
    logic                was_new;
    logic [LPOS_W-1:0]   list_position;
    logic [STATUS_W-1:0] status;
  } index_result_t;

  // Block ports.
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  kind = 1'b0;
  logic [VWORD_W-1:0]    vertex_word_0 = '0;
  logic [VWORD_W-1:0]    vertex_word_1 = '0;
  logic [VWORD_W-1:0]    vertex_word_2 = '0;
  logic [VWORD_W-1:0]    vertex_word_3 = '0;
  logic [VWORD_W-1:0]    vertex_word_4 = '0;
  logic [VWORD_W-1:0]    vertex_word_5 = '0;
  logic [VLAST_W-1:0]    vertex_word_6 = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [VIDX_W-1:0]     vertex_index;
  logic                  was_new;
  logic [LPOS_W-1:0]     list_position;
  logic [STATUS_W-1:0]   status;

  // Shadow copy of the dedup state and the limit registers.
  vertex_t             known_vertices[$];
  int                  tri_fill = 0;
  int                  line_fill = 0;
  logic [VLIM_W-1:0]   vlimit_reg = VLIM_RESET;
  logic [ILIM_W-1:0]   tri_limit_reg = ILIM_RESET;
  logic [ILIM_W-1:0]   line_limit_reg = ILIM_RESET;

  // Stimulus and scoreboard bookkeeping.
  vertex_beat_t  vertex_feed[$];
  vertex_t       seen_vertices[$];
  index_result_t expected_results[$];
  vertex_beat_t  cur_beat;
  index_result_t want_result;
  index_result_t got_result;
  int queued_count = 0;
  int accepted_count = 0;
  int checked_count = 0;
  int mismatch_count = 0;
  int new_count = 0;
  int reuse_count = 0;
  int table_full_count = 0;
  int list_full_count = 0;
  int reg_write_count = 0;
  int cycle_count = 0;
  int send_gap_max = 9;
  int recv_gap_max = 9;
  int send_wait = 0;
  int recv_wait = 0;
  bit hold_armed = 1'b0;
  logic receiver_hold = 1'b0;

  vertex_dedup_index_builder_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .vertex_word_0 (vertex_word_0),
    .vertex_word_1 (vertex_word_1),
    .vertex_word_2 (vertex_word_2),
    .vertex_word_3 (vertex_word_3),
    .vertex_word_4 (vertex_word_4),
    .vertex_word_5 (vertex_word_5),
    .vertex_word_6 (vertex_word_6),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .vertex_index  (vertex_index),
    .was_new       (was_new),
    .list_position (list_position),
    .status        (status)
  );

  // Free-running clock.
  always #(CLK_PERIOD / 2) clk = ~clk;

  // A limit register above the storage depth behaves as the depth.
  function automatic int cap_at(input int value, input int depth);
    return (value < depth) ? value : depth;
  endfunction

  // Predicts the outcome of one vertex and updates the shadow table and fills.
  function automatic index_result_t dedup_lookup(input vertex_beat_t beat);
    index_result_t res;
    int fill;
    int list_cap;
    int table_cap;
    int hit;
    int i;
    res = '0;
    res.status = STATUS_OK;
    fill = beat.kind ? line_fill : tri_fill;
    list_cap = cap_at(beat.kind ? int'(line_limit_reg) : int'(tri_limit_reg),
                      INDEX_DEPTH_DEFAULT);
    table_cap = cap_at(int'(vlimit_reg), TABLE_DEPTH_DEFAULT);
    // The chosen index list is checked before the table is searched.
    if (fill >= list_cap) begin
      res.status = STATUS_LIST_FULL;
      return res;
    end
    hit = -1;
    for (i = 0; i < known_vertices.size() && hit < 0; i++) begin
      if (known_vertices[i] == beat.vtx) hit = i;
    end
    // No match: append, unless the table has no room left.
    if (hit < 0) begin
      if (known_vertices.size() >= table_cap) begin
        res.status = STATUS_TABLE_FULL;
        return res;
      end
      hit = known_vertices.size();
      known_vertices.push_back(beat.vtx);
      res.was_new = 1'b1;
    end
    res.vertex_index = VIDX_W'(hit);
    res.list_position = LPOS_W'(fill);
    if (beat.kind) line_fill++;
    else tri_fill++;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input index_result_t want,
                                 input index_result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("tb_top: %s at cycle %0d", what, cycle_count);
      $display("  expected idx=%0d new=%0b pos=%0d status=%0d", want.vertex_index,
               want.was_new, want.list_position, want.status);
      $display("  actual   idx=%0d new=%0b pos=%0d status=%0d", got.vertex_index,
               got.was_new, got.list_position, got.status);
    end
  endtask

  // Input driver: sends queued vertices, with a random pause before each beat.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(dedup_lookup(cur_beat));
        accepted_count++;
        send_wait = $urandom_range(send_gap_max, 0);
      end
      if (!in_valid || in_ready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (vertex_feed.size() > 0) begin
          cur_beat = vertex_feed.pop_front();
          in_valid <= 1'b1;
          kind <= cur_beat.kind;
          vertex_word_0 <= cur_beat.vtx[0 * VWORD_W +: VWORD_W];
          vertex_word_1 <= cur_beat.vtx[1 * VWORD_W +: VWORD_W];
          vertex_word_2 <= cur_beat.vtx[2 * VWORD_W +: VWORD_W];
          vertex_word_3 <= cur_beat.vtx[3 * VWORD_W +: VWORD_W];
          vertex_word_4 <= cur_beat.vtx[4 * VWORD_W +: VWORD_W];
          vertex_word_5 <= cur_beat.vtx[5 * VWORD_W +: VWORD_W];
          vertex_word_6 <= cur_beat.vtx[6 * VWORD_W +: VLAST_W];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each beat against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        got_result = {vertex_index, was_new, list_position, status};
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", '0, got_result);
        end else begin
          want_result = expected_results.pop_front();
          checked_count++;
          if (got_result.vertex_index !== want_result.vertex_index ||
              got_result.was_new !== want_result.was_new ||
              got_result.list_position !== want_result.list_position ||
              got_result.status !== want_result.status) begin
            report_mismatch("result mismatch", want_result, got_result);
          end
          case (want_result.status)
            STATUS_TABLE_FULL: table_full_count++;
            STATUS_LIST_FULL:  list_full_count++;
            default: begin
              if (want_result.was_new) new_count++;
              else reuse_count++;
            end
          endcase
        end
        recv_wait = $urandom_range(recv_gap_max, 0);
      end
      if (receiver_hold) begin
        out_ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off, so the block backs up and stops taking vertices.
  initial begin
    wait (hold_armed);
    @(posedge clk);
    receiver_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    receiver_hold <= 1'b0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic offer(input logic lane, input vertex_t v);
    vertex_beat_t beat;
    beat.kind = lane;
    beat.vtx = v;
    vertex_feed.push_back(beat);
    seen_vertices.push_back(v);
    queued_count++;
  endtask

  // Register write; only issued while nothing is in flight.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'(value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    reg_write_count++;
    case (idx)
      CFG_VERTEX_LIMIT:   vlimit_reg = data[VLIM_W-1:0];
      CFG_TRIANGLE_LIMIT: tri_limit_reg = data[ILIM_W-1:0];
      CFG_LINE_LIMIT:     line_limit_reg = data[ILIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(input int vlim, input int tlim, input int llim);
    write_reg(CFG_VERTEX_LIMIT, vlim);
    write_reg(CFG_TRIANGLE_LIMIT, tlim);
    write_reg(CFG_LINE_LIMIT, llim);
  endtask

  // Every vertex sent has been taken and every result has come back.
  task automatic wait_drained();
    while (accepted_count != queued_count || expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic vertex_t fresh_vertex();
    vertex_t v;
    int w;
    logic pin;
    for (w = 0; w < VERTEX_W / 32; w++) v[w * 32 +: 32] = $urandom();
    // Now and then pin one whole word to all zeros or all ones.
    if ($urandom_range(3, 0) == 0) begin
      w = $urandom_range(6, 0);
      pin = 1'($urandom_range(1, 0));
      if (w == 6) v[6 * VWORD_W +: VLAST_W] = {VLAST_W{pin}};
      else v[w * VWORD_W +: VWORD_W] = {VWORD_W{pin}};
    end
    return v;
  endfunction

  // Random primitives: triangles of three, lines of two, a few cut short.
  // Vertices are fresh, repeats (recent or old) or one-bit near misses.
  task automatic random_burst(input int count);
    int sent;
    int prim_len;
    int k;
    int pick;
    int bit_pos;
    logic lane;
    vertex_t v;
    sent = 0;
    while (sent < count) begin
      lane = 1'($urandom_range(1, 0));
      prim_len = lane ? 2 : 3;
      if ($urandom_range(9, 0) == 0) prim_len = 1;
      for (k = 0; k < prim_len && sent < count; k++) begin
        pick = $urandom_range(99, 0);
        if (seen_vertices.size() == 0 || pick < 40) begin
          v = fresh_vertex();
        end else if (pick < 55) begin
          v = seen_vertices[seen_vertices.size() - 1];
        end else begin
          v = seen_vertices[$urandom_range(seen_vertices.size() - 1, 0)];
          if (pick >= 85) begin
            bit_pos = $urandom_range(VERTEX_W - 1, 0);
            v[bit_pos] = ~v[bit_pos];
          end
        end
        offer(lane, v);
        sent++;
      end
    end
  endtask

  // Main sequence.
  initial begin
    vertex_t zero_v;
    vertex_t ones_v;
    vertex_t a_v;
    vertex_t b_v;
    vertex_t t_v;
    zero_v = '0;
    ones_v = '1;
    a_v = fresh_vertex();
    b_v = fresh_vertex();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset limits: extremes, repeats, a duplicate inside one triangle and
    // single-bit differences at both ends of the vertex.
    offer(1'b0, zero_v);
    offer(1'b1, ones_v);
    offer(1'b0, zero_v);
    offer(1'b0, a_v);
    offer(1'b0, a_v);
    offer(1'b0, b_v);
    t_v = zero_v;
    t_v[VERTEX_W - 1] = 1'b1;
    offer(1'b1, t_v);
    t_v = zero_v;
    t_v[0] = 1'b1;
    offer(1'b0, t_v);
    t_v = ones_v;
    t_v[6 * VWORD_W +: VLAST_W] = '0;
    offer(1'b0, t_v);
    offer(1'b1, ones_v);
    wait_drained();

    // Table exactly full, three triangle slots left, line list closed.
    set_limits(known_vertices.size(), tri_fill + 3, 0);
    offer(1'b0, fresh_vertex());
    offer(1'b0, zero_v);
    offer(1'b1, zero_v);
    offer(1'b0, ones_v);
    offer(1'b0, a_v);
    offer(1'b0, b_v);
    offer(1'b0, fresh_vertex());
    wait_drained();

    // Zero vertex limit, limits above depth, exact maximum, unused index.
    set_limits(0, (1 << CFG_DATA_W) - 1, ILIM_RESET);
    write_reg(CFG_UNUSED, $urandom_range((1 << CFG_DATA_W) - 1, 0));
    offer(1'b1, fresh_vertex());
    offer(1'b1, ones_v);
    offer(1'b0, b_v);
    wait_drained();

    // Roomy limits, idling on both sides.
    set_limits((1 << CFG_DATA_W) - 1, ILIM_RESET, (1 << CFG_DATA_W) - 1);
    random_burst(200);
    wait_drained();

    // Tight limits so both kinds of overflow show up mid-stream.
    set_limits(known_vertices.size() + 15, tri_fill + 20, line_fill + 20);
    random_burst(80);
    wait_drained();

    // Back-pressure: sender never idles while the receiver holds off.
    set_limits(VLIM_RESET, ILIM_RESET, ILIM_RESET);
    send_gap_max = 0;
    hold_armed = 1'b1;
    random_burst(120);
    wait_drained();

    // Random limits, first without idling, then with.
    set_limits($urandom_range((1 << VLIM_W) - 1, known_vertices.size()),
               $urandom_range((1 << CFG_DATA_W) - 1, tri_fill + 60),
               $urandom_range((1 << CFG_DATA_W) - 1, line_fill + 60));
    recv_gap_max = 0;
    random_burst(80);
    wait_drained();
    send_gap_max = 9;
    recv_gap_max = 9;
    random_burst(100);
    wait_drained();

    // Let any stray result show up before closing.
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("tb_top: %0d vertices, %0d results checked: %0d appended, %0d reused,",
             accepted_count, checked_count, new_count, reuse_count);
    $display("tb_top: %0d table-full, %0d list-full, %0d register writes, %0d in table",
             table_full_count, list_full_count, reg_write_count, known_vertices.size());
    if (mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: %0d mismatches", mismatch_count);
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== vertex_dedup_index_builder_unit.f =====
hw/rtl/vdib_pkg.sv
hw/rtl/vdib_ram.sv
hw/rtl/vertex_dedup_index_builder_unit.sv
hw/rtl/vdib_checker.sv
verif/tb_top.sv
